// ===== rtl/core/http_response_head_parser_assert.svh =====
// assertion macros for the http response head parser
`ifndef HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH

// a implies c in the same cycle
`define HRHP_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("hrhp: same-cycle implication failed");

// a implies c in the next cycle
`define HRHP_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("hrhp: next-cycle implication failed");

`endif

// ===== rtl/core/hrhp_pkg.sv =====
// shared types, constants and character tables for the http response head parser
`default_nettype none
package hrhp_pkg;

	localparam int MAX_BUFFER_BYTES = 65536;
	localparam int CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int HDR_W = 17;
	localparam int MIN_LEN = 12;

	localparam logic [1:0] OUTCOME_OK        = 2'd0;
	localparam logic [1:0] OUTCOME_MALFORMED = 2'd1;
	localparam logic [1:0] OUTCOME_NO_END    = 2'd2;

	// header line scan phases; values below PH_COLON are name match positions
	localparam logic [4:0] PH_COLON  = 5'd14;
	localparam logic [4:0] PH_MISS   = 5'd15;
	localparam logic [4:0] PH_SPACES = 5'd16;
	localparam logic [4:0] PH_DIGITS = 5'd17;
	localparam logic [4:0] PH_FOUND  = 5'd18;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [23:0] CR_LF_CR = 24'h0d0a0d;

	typedef struct packed {
		logic [1:0]       outcome;
		logic [9:0]       status_code;
		logic [HDR_W-1:0] header_bytes;
		logic [31:0]      body_bytes;
		logic             length_saturated;
	} result_t;

	function automatic logic [7:0] http_tag_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h48; // H
			3'd1: ch = 8'h54; // T
			3'd2: ch = 8'h54; // T
			3'd3: ch = 8'h50; // P
			3'd4: ch = 8'h2f; // /
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:  ch = 8'h43; // C
			4'd1:  ch = 8'h6f; // o
			4'd2:  ch = 8'h6e; // n
			4'd3:  ch = 8'h74; // t
			4'd4:  ch = 8'h65; // e
			4'd5:  ch = 8'h6e; // n
			4'd6:  ch = 8'h74; // t
			4'd7:  ch = 8'h2d; // -
			4'd8:  ch = 8'h4c; // L
			4'd9:  ch = 8'h65; // e
			4'd10: ch = 8'h6e; // n
			4'd11: ch = 8'h67; // g
			4'd12: ch = 8'h74; // t
			4'd13: ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/http_response_head_parser.sv =====
// http response head parser: one byte per cycle in, one result per response out
// the result is registered in the output register once the last byte has passed the input stage
// throughput: one byte per cycle unless a last byte is stalled, limited by the single state update stage
// a stalled result holds back only a following last byte; other bytes keep flowing
// reset: arst_n clears the input stage, the output valid and all parse state
`default_nettype none
module http_response_head_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,  // final_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata   // [1:0] outcome, [11:2] status_code,
	                                        // [28:12] header_bytes, [60:29] body_bytes,
	                                        // [61] length_saturated, [63:62] zero
);

	`include "http_response_head_parser_assert.svh"

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	hrhp_pkg::result_t core_res;
	hrhp_pkg::result_t res_q;
	logic              out_valid_q;

	// a last byte waits only while the output register is still full and not being taken
	assign advance       = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	hrhp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.final_byte (last_s1),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.length_saturated, res_q.body_bytes,
		res_q.header_bytes, res_q.status_code, res_q.outcome};

	`HRHP_ASSERT_IMPLY(a_malformed_zero, clk, arst_n,
		out_valid_q && res_q.outcome == hrhp_pkg::OUTCOME_MALFORMED,
		res_q.status_code == '0 && res_q.header_bytes == '0 && res_q.body_bytes == '0)
	`HRHP_ASSERT_IMPLY(a_ok_has_header, clk, arst_n,
		out_valid_q && res_q.outcome == hrhp_pkg::OUTCOME_OK,
		res_q.header_bytes != '0)
	`HRHP_ASSERT_IMPLY(a_stall_cause, clk, arst_n,
		!s_axis_tready,
		valid_s1 && last_s1 && out_valid_q && !m_axis_tready)
	`HRHP_ASSERT_NEXT(a_last_loads_output, clk, arst_n,
		advance && last_s1,
		out_valid_q)

endmodule
`default_nettype wire

// ===== rtl/core/hrhp_core.sv =====
// running parse state of one response and the result computed on its last byte
`default_nettype none
module hrhp_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       data_byte,
	input  wire logic             final_byte,
	output hrhp_pkg::result_t     res
);

	localparam int CW = hrhp_pkg::CNT_W;

	logic [CW-1:0] byte_count_q, byte_count_d;
	logic          prefix_bad_q, prefix_bad_d;
	logic          space_found_q, space_found_d;
	logic [CW-1:0] space_offset_q, space_offset_d;
	logic [9:0]    status_value_q, status_value_d;
	logic [1:0]    status_count_q, status_count_d;
	logic          status_bad_q, status_bad_d;
	logic [23:0]   recent_q, recent_d;
	logic [CW-1:0] header_end_q, header_end_d;
	logic [4:0]    phase_q, phase_d;
	logic [31:0]   length_q, length_d;
	logic          length_sat_q, length_sat_d;

	logic          take;
	logic          is_digit;
	logic [3:0]    digit;
	logic [13:0]   status_mul;
	logic [35:0]   length_mul;
	logic          bad;
	logic [CW:0]   space_end;

	always_comb begin
		byte_count_d   = byte_count_q;
		prefix_bad_d   = prefix_bad_q;
		space_found_d  = space_found_q;
		space_offset_d = space_offset_q;
		status_value_d = status_value_q;
		status_count_d = status_count_q;
		status_bad_d   = status_bad_q;
		recent_d       = recent_q;
		header_end_d   = header_end_q;
		phase_d        = phase_q;
		length_d       = length_q;
		length_sat_d   = length_sat_q;

		take     = byte_count_q < CW'(hrhp_pkg::MAX_BUFFER_BYTES);
		is_digit = data_byte >= hrhp_pkg::CH_ZERO && data_byte <= hrhp_pkg::CH_NINE;
		digit    = data_byte[3:0];
		status_mul = {1'b0, status_value_q, 3'b000} + {3'b000, status_value_q, 1'b0}
			+ {10'd0, digit};
		length_mul = {1'b0, length_q, 3'b000} + {3'b000, length_q, 1'b0} + {32'd0, digit};

		if (take) begin
			if (byte_count_q < CW'(5) &&
				data_byte != hrhp_pkg::http_tag_char(byte_count_q[2:0])) begin
				prefix_bad_d = 1'b1;
			end

			// first space, then three status characters after it
			if (!space_found_q) begin
				if (data_byte == hrhp_pkg::CH_SPACE) begin
					space_found_d  = 1'b1;
					space_offset_d = byte_count_q;
				end
			end else if (status_count_q < 2'd3) begin
				if (is_digit)
					status_value_d = status_mul[9:0];
				else
					status_bad_d = 1'b1;
				status_count_d = status_count_q + 2'd1;
			end

			if (header_end_q == '0) begin
				if (phase_q < hrhp_pkg::PH_COLON) begin
					phase_d = (data_byte == hrhp_pkg::cl_name_char(phase_q[3:0]))
						? phase_q + 5'd1 : hrhp_pkg::PH_MISS;
				end else if (phase_q == hrhp_pkg::PH_COLON) begin
					phase_d = (data_byte == hrhp_pkg::CH_COLON)
						? hrhp_pkg::PH_SPACES : hrhp_pkg::PH_MISS;
				end else if (phase_q == hrhp_pkg::PH_MISS) begin
					if (data_byte == hrhp_pkg::CH_LF && recent_q[7:0] == hrhp_pkg::CH_CR)
						phase_d = 5'd0;
				end else if (phase_q == hrhp_pkg::PH_SPACES ||
					phase_q == hrhp_pkg::PH_DIGITS) begin
					if (phase_q == hrhp_pkg::PH_SPACES && data_byte == hrhp_pkg::CH_SPACE) begin
						phase_d = phase_q;
					end else if (is_digit) begin
						phase_d = hrhp_pkg::PH_DIGITS;
						// saturate once the value leaves 32 bits
						if (length_mul[35:32] != 4'd0) begin
							length_d     = '1;
							length_sat_d = 1'b1;
						end else begin
							length_d = length_mul[31:0];
						end
					end else begin
						phase_d = hrhp_pkg::PH_FOUND;
					end
				end

				if (data_byte == hrhp_pkg::CH_LF && recent_q == hrhp_pkg::CR_LF_CR)
					header_end_d = byte_count_q + CW'(1);
			end

			recent_d     = {recent_q[15:0], data_byte};
			byte_count_d = byte_count_q + CW'(1);
		end

		space_end = {1'b0, space_offset_d} + (CW+1)'(4);
		bad = byte_count_d < CW'(hrhp_pkg::MIN_LEN) || prefix_bad_d || !space_found_d ||
			space_end >= {1'b0, byte_count_d} || status_count_d != 2'd3 || status_bad_d;

		res = '0;
		if (bad) begin
			res.outcome = hrhp_pkg::OUTCOME_MALFORMED;
		end else if (header_end_d == '0) begin
			res.outcome     = hrhp_pkg::OUTCOME_NO_END;
			res.status_code = status_value_d;
		end else begin
			res.outcome      = hrhp_pkg::OUTCOME_OK;
			res.status_code  = status_value_d;
			res.header_bytes = hrhp_pkg::HDR_W'(header_end_d);
			if (phase_d >= hrhp_pkg::PH_SPACES) begin
				res.body_bytes       = length_d;
				res.length_saturated = length_sat_d;
			end else begin
				res.body_bytes = 32'(byte_count_d - header_end_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			prefix_bad_q   <= 1'b0;
			space_found_q  <= 1'b0;
			space_offset_q <= '0;
			status_value_q <= '0;
			status_count_q <= '0;
			status_bad_q   <= 1'b0;
			recent_q       <= '0;
			header_end_q   <= '0;
			phase_q        <= '0;
			length_q       <= '0;
			length_sat_q   <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				// response done: start clean for the next one
				byte_count_q   <= '0;
				prefix_bad_q   <= 1'b0;
				space_found_q  <= 1'b0;
				space_offset_q <= '0;
				status_value_q <= '0;
				status_count_q <= '0;
				status_bad_q   <= 1'b0;
				recent_q       <= '0;
				header_end_q   <= '0;
				phase_q        <= '0;
				length_q       <= '0;
				length_sat_q   <= 1'b0;
			end else begin
				byte_count_q   <= byte_count_d;
				prefix_bad_q   <= prefix_bad_d;
				space_found_q  <= space_found_d;
				space_offset_q <= space_offset_d;
				status_value_q <= status_value_d;
				status_count_q <= status_count_d;
				status_bad_q   <= status_bad_d;
				recent_q       <= recent_d;
				header_end_q   <= header_end_d;
				phase_q        <= phase_d;
				length_q       <= length_d;
				length_sat_q   <= length_sat_d;
			end
		end
	end

endmodule
`default_nettype wire
